// File: hdl/ucc_pkg.sv
package ucc_pkg;

   localparam int TOTAL_BITS = 32;
   localparam int CP_BITS = 21;
   localparam int OUT_TOTAL_BITS = 32;

   localparam logic [1:0] CONT_TAG = 2'b10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       before_caret;
      logic       last_byte;
   } ucc_item_type;

   typedef struct packed {
      logic [CP_BITS-1:0]        code_point;
      logic [1:0]                char_width;
      logic                      char_done;
      logic [OUT_TOTAL_BITS-1:0] column_total;
      logic [OUT_TOTAL_BITS-1:0] char_total;
      logic                      text_done;
   } ucc_result_type;

   typedef struct packed {
      logic [1:0]            bytes_owed;
      logic [7:0]            lead_held;
      logic [CP_BITS-1:0]    partial_value;
      logic                  bad_sequence;
      logic                  inside_text;
      logic                  char_counted;
      logic [TOTAL_BITS-1:0] columns_acc;
      logic [TOTAL_BITS-1:0] chars_acc;
   } ucc_state_type;

   localparam ucc_state_type STATE_CLEAR = '0;

endpackage

// File: hdl/ucc_channels.sv
interface ucc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       before_caret;
   logic       last_byte;

   modport source (output valid, output data_byte, output before_caret, output last_byte,
                   input ready);
   modport sink (input valid, input data_byte, input before_caret, input last_byte,
                 output ready);
endinterface

interface ucc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ucc_pkg::CP_BITS-1:0]         code_point;
   logic [1:0]                          char_width;
   logic                                char_done;
   logic [ucc_pkg::OUT_TOTAL_BITS-1:0]  column_total;
   logic [ucc_pkg::OUT_TOTAL_BITS-1:0]  char_total;
   logic                                text_done;

   modport source (output valid, output code_point, output char_width, output char_done,
                   output column_total, output char_total, output text_done,
                   input ready);
   modport sink (input valid, input code_point, input char_width, input char_done,
                 input column_total, input char_total, input text_done,
                 output ready);
endinterface

// File: hdl/utf8_decode_column_counter.sv
// Decodes a UTF-8 byte stream and returns one result item for every byte taken, carrying the
// settled code point and display width when a character completes, and running saturated
// totals of counted characters and columns. It takes one byte per clock while the result
// output is not stalled: a byte waits in the input register, the decode step and the width
// lookup update the decoder state as the byte moves on to the output register, and the result
// is held in the output register until it is taken. All state, totals included, clears after the result of
// the last byte of a text.
module utf8_decode_column_counter (
   input  logic            clock,
   input  logic            reset,
   ucc_req_if.sink         req,
   ucc_rsp_if.source       rsp
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   ucc_pkg::ucc_item_type   in_item_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   ucc_pkg::ucc_result_type rsp_data_ff;
   ucc_pkg::ucc_state_type  state_ff;
   ucc_pkg::ucc_state_type  state_in;
   ucc_pkg::ucc_result_type step_result;
   logic                    advance;
   logic                    take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign take      = req.valid && req.ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp.ready);

   ucc_step u_step (
      .item       (in_item_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ucc_pkg::STATE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff.data_byte    <= req.data_byte;
         in_item_ff.before_caret <= req.before_caret;
         in_item_ff.last_byte    <= req.last_byte;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.code_point   = rsp_data_ff.code_point;
   assign rsp.char_width   = rsp_data_ff.char_width;
   assign rsp.char_done    = rsp_data_ff.char_done;
   assign rsp.column_total = rsp_data_ff.column_total;
   assign rsp.char_total   = rsp_data_ff.char_total;
   assign rsp.text_done    = rsp_data_ff.text_done;

endmodule

// File: hdl/ucc_width.sv
module ucc_width (
   input  logic [ucc_pkg::CP_BITS-1:0] code_point,
   output logic [1:0]                  char_width
);

   always_comb begin
      if (code_point inside {[21'h000300:21'h00036F], [21'h00064B:21'h00065F],
                             21'h000670, [21'h0006D6:21'h0006ED],
                             [21'h00200B:21'h00200F]}) begin
         char_width = 2'd0;
      end else if (code_point inside {[21'h001100:21'h00115F], [21'h002E80:21'h00303E],
                                      [21'h003041:21'h0033FF], [21'h003400:21'h004DBF],
                                      [21'h004E00:21'h009FFF], [21'h00A000:21'h00A4CF],
                                      [21'h00AC00:21'h00D7A3], [21'h00F900:21'h00FAFF],
                                      [21'h00FE30:21'h00FE6F], [21'h00FF00:21'h00FF60],
                                      [21'h00FFE0:21'h00FFE6], [21'h01F300:21'h01F64F],
                                      [21'h01F900:21'h01F9FF],
                                      [21'h020000:21'h03FFFD]}) begin
         char_width = 2'd2;
      end else begin
         char_width = 2'd1;
      end
   end

endmodule

// File: hdl/ucc_step.sv
module ucc_step (
   input  ucc_pkg::ucc_item_type   item,
   input  ucc_pkg::ucc_state_type  state,
   output ucc_pkg::ucc_state_type  state_next,
   output ucc_pkg::ucc_result_type result
);

   logic [ucc_pkg::CP_BITS-1:0] cp;
   logic                        done;
   logic                        cont;
   logic [2:0]                  claim;
   logic [1:0]                  width;
   logic [ucc_pkg::TOTAL_BITS:0] chars_sum;
   logic [ucc_pkg::TOTAL_BITS:0] cols_sum;
   ucc_pkg::ucc_state_type       ns;

   assign cont = (item.data_byte[7:6] == ucc_pkg::CONT_TAG);

   always_comb begin
      case (item.data_byte) inside
         [8'h00:8'h7F]: claim = 3'd1;
         [8'hC0:8'hDF]: claim = 3'd2;
         [8'hE0:8'hEF]: claim = 3'd3;
         [8'hF0:8'hF7]: claim = 3'd4;
         default:       claim = 3'd1;
      endcase
   end

   ucc_width u_width (
      .code_point (cp),
      .char_width (width)
   );

   assign chars_sum = {1'b0, state.chars_acc} + (ucc_pkg::TOTAL_BITS+1)'(1);

   always_comb begin
      ns   = state;
      done = 1'b0;
      cp   = '0;
      if (state.bytes_owed != 2'd0) begin
         if (cont) begin
            ns.partial_value = {state.partial_value[ucc_pkg::CP_BITS-7:0],
                                item.data_byte[5:0]};
         end else begin
            ns.bad_sequence = 1'b1;
         end
         ns.bytes_owed = state.bytes_owed - 2'd1;
         if (ns.bytes_owed == 2'd0) begin
            done = 1'b1;
            cp   = ns.bad_sequence ? ucc_pkg::CP_BITS'(state.lead_held) : ns.partial_value;
         end else if (item.last_byte) begin
            done = 1'b1;
            cp   = ucc_pkg::CP_BITS'(state.lead_held);
         end
      end else if (!(state.inside_text && cont)) begin
         ns.inside_text  = 1'b1;
         ns.lead_held    = item.data_byte;
         ns.bad_sequence = 1'b0;
         ns.char_counted = item.before_caret;
         if (item.before_caret) begin
            ns.chars_acc = chars_sum[ucc_pkg::TOTAL_BITS] ?
                           '1 : chars_sum[ucc_pkg::TOTAL_BITS-1:0];
         end
         case (claim)
            3'd2:    ns.partial_value = ucc_pkg::CP_BITS'(item.data_byte & 8'h1F);
            3'd3:    ns.partial_value = ucc_pkg::CP_BITS'(item.data_byte & 8'h0F);
            3'd4:    ns.partial_value = ucc_pkg::CP_BITS'(item.data_byte & 8'h07);
            default: ns.partial_value = ucc_pkg::CP_BITS'(item.data_byte & 8'h7F);
         endcase
         done = (claim == 3'd1) || item.last_byte;
         cp   = ucc_pkg::CP_BITS'(item.data_byte);
         if (claim != 3'd1) begin
            ns.bytes_owed = 2'(claim - 3'd1);
         end
      end
   end

   assign cols_sum = {1'b0, ns.columns_acc} + (ucc_pkg::TOTAL_BITS+1)'(width);

   always_comb begin
      state_next = ns;
      if (done && ns.char_counted) begin
         state_next.columns_acc = cols_sum[ucc_pkg::TOTAL_BITS] ?
                                  '1 : cols_sum[ucc_pkg::TOTAL_BITS-1:0];
      end
      result.code_point   = done ? cp : '0;
      result.char_width   = done ? width : 2'd0;
      result.char_done    = done;
      result.column_total = ucc_pkg::OUT_TOTAL_BITS'(state_next.columns_acc);
      result.char_total   = ucc_pkg::OUT_TOTAL_BITS'(state_next.chars_acc);
      result.text_done    = item.last_byte;
      if (item.last_byte) begin
         state_next = ucc_pkg::STATE_CLEAR;
      end
   end

endmodule

// File: dv/utf8_decode_column_counter_tb.sv
module utf8_decode_column_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ucc_pkg::*;

   class column_scoreboard;
      ucc_result_type        pending_results[$];
      int                    fail_count = 0;
      int                    chars_settled = 0;
      int                    texts_seen = 0;
      int unsigned           owed = 0;
      logic [7:0]            lead = '0;
      logic [CP_BITS-1:0]    partial = '0;
      bit                    bad = 1'b0;
      bit                    in_text = 1'b0;
      bit                    counted_char = 1'b0;
      logic [TOTAL_BITS-1:0] col_acc = '0;
      logic [TOTAL_BITS-1:0] chr_acc = '0;

      function void clear_text();
         owed = 0;
         lead = '0;
         partial = '0;
         bad = 1'b0;
         in_text = 1'b0;
         counted_char = 1'b0;
         col_acc = '0;
         chr_acc = '0;
      endfunction

      function int lead_claim(logic [7:0] b);
         if (b[7] == 1'b0) return 1;
         if (b[7:5] == 3'b110) return 2;
         if (b[7:4] == 4'b1110) return 3;
         if (b[7:3] == 5'b11110) return 4;
         return 1;
      endfunction

      function bit span(int unsigned v, int unsigned lo, int unsigned hi);
         return v >= lo && v <= hi;
      endfunction

      function logic [1:0] display_columns(logic [CP_BITS-1:0] c);
         int unsigned v;
         v = c;
         if (span(v, 'h0300, 'h036F) || span(v, 'h064B, 'h065F) || v == 'h0670 ||
             span(v, 'h06D6, 'h06ED) || span(v, 'h200B, 'h200F))
            return 2'd0;
         if (span(v, 'h1100, 'h115F) || span(v, 'h2E80, 'h303E) ||
             span(v, 'h3041, 'h33FF) || span(v, 'h3400, 'h4DBF) ||
             span(v, 'h4E00, 'h9FFF) || span(v, 'hA000, 'hA4CF) ||
             span(v, 'hAC00, 'hD7A3) || span(v, 'hF900, 'hFAFF) ||
             span(v, 'hFE30, 'hFE6F) || span(v, 'hFF00, 'hFF60) ||
             span(v, 'hFFE0, 'hFFE6) || span(v, 'h1F300, 'h1F64F) ||
             span(v, 'h1F900, 'h1F9FF) || span(v, 'h20000, 'h3FFFD))
            return 2'd2;
         return 2'd1;
      endfunction

      function logic [TOTAL_BITS-1:0] sat_add(logic [TOTAL_BITS-1:0] acc, int unsigned d);
         logic [TOTAL_BITS:0] sum;
         sum = {1'b0, acc} + (TOTAL_BITS+1)'(d);
         if (sum[TOTAL_BITS]) return '1;
         return sum[TOTAL_BITS-1:0];
      endfunction

      function void note_byte(ucc_item_type it);
         ucc_result_type     r;
         logic [7:0]         b;
         bit                 done;
         logic [CP_BITS-1:0] cp;
         int                 len;
         b = it.data_byte;
         done = 1'b0;
         cp = '0;
         r = '0;
         if (owed > 0) begin
            if (b[7:6] == CONT_TAG) begin
               partial = {partial[CP_BITS-7:0], b[5:0]};
            end else begin
               bad = 1'b1;
            end
            owed--;
            if (owed == 0) begin
               done = 1'b1;
               cp = bad ? CP_BITS'(lead) : partial;
            end else if (it.last_byte) begin
               done = 1'b1;
               cp = CP_BITS'(lead);
            end
         end else if (!(in_text && b[7:6] == CONT_TAG)) begin
            len = lead_claim(b);
            in_text = 1'b1;
            lead = b;
            bad = 1'b0;
            counted_char = it.before_caret;
            if (it.before_caret) chr_acc = sat_add(chr_acc, 1);
            partial = CP_BITS'(b & (8'hFF >> (len + 1)));
            if (len == 1) begin
               done = 1'b1;
               cp = CP_BITS'(b);
            end else begin
               owed = len - 1;
               if (it.last_byte) begin
                  done = 1'b1;
                  cp = CP_BITS'(lead);
               end
            end
         end
         if (done) begin
            r.char_width = display_columns(cp);
            if (counted_char) col_acc = sat_add(col_acc, r.char_width);
            chars_settled++;
         end
         r.code_point = cp;
         r.char_done = done;
         r.column_total = OUT_TOTAL_BITS'(col_acc);
         r.char_total = OUT_TOTAL_BITS'(chr_acc);
         r.text_done = it.last_byte;
         pending_results.push_back(r);
         if (it.last_byte) begin
            clear_text();
            texts_seen++;
         end
      endfunction

      function void check_result(ucc_result_type got);
         ucc_result_type want;
         if (pending_results.size() == 0) begin
            $error("result item with nothing expected: %p", got);
            fail_count++;
            return;
         end
         want = pending_results.pop_front();
         if (got.code_point !== want.code_point) begin
            $error("code_point: expected %0h, got %0h", want.code_point, got.code_point);
            fail_count++;
         end
         if (got.char_width !== want.char_width) begin
            $error("char_width: expected %0d, got %0d", want.char_width, got.char_width);
            fail_count++;
         end
         if (got.char_done !== want.char_done) begin
            $error("char_done: expected %0b, got %0b", want.char_done, got.char_done);
            fail_count++;
         end
         if (got.column_total !== want.column_total) begin
            $error("column_total: expected %0d, got %0d", want.column_total, got.column_total);
            fail_count++;
         end
         if (got.char_total !== want.char_total) begin
            $error("char_total: expected %0d, got %0d", want.char_total, got.char_total);
            fail_count++;
         end
         if (got.text_done !== want.text_done) begin
            $error("text_done: expected %0b, got %0b", want.text_done, got.text_done);
            fail_count++;
         end
      endfunction
   endclass

   localparam int PHASE_BYTES = 390;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   rsp_hold = 1'b0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   bytes_sent = 0;

   column_scoreboard sb;

   int unsigned cp_edges[44] = '{
      'h7F, 'h80, 'h7FF, 'h800, 'hFFFF, 'h10000, 'h0300, 'h036F, 'h064B, 'h065F, 'h0670,
      'h06D6, 'h06ED, 'h200B, 'h200F, 'h1100, 'h115F, 'h2E80, 'h303E, 'h3041, 'h33FF,
      'h3400, 'h4DBF, 'h4E00, 'h9FFF, 'hA000, 'hA4CF, 'hAC00, 'hD7A3, 'hF900, 'hFAFF,
      'hFE30, 'hFE6F, 'hFF00, 'hFF60, 'hFFE0, 'hFFE6, 'h1F300, 'h1F64F, 'h1F900,
      'h1F9FF, 'h20000, 'h3FFFD, 'h1FFFFF};

   ucc_req_if req_ch ();
   ucc_rsp_if rsp_ch ();

   utf8_decode_column_counter dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #5 clock = ~clock;

   function automatic int natural_len(logic [20:0] cp);
      if (cp < 21'h80) return 1;
      if (cp < 21'h800) return 2;
      if (cp < 21'h10000) return 3;
      return 4;
   endfunction

   function automatic void push_char(ref logic [7:0] bytes[$], input logic [20:0] cp,
                                     input int len);
      case (len)
         1: bytes.push_back({1'b0, cp[6:0]});
         2: begin
            bytes.push_back({3'b110, cp[10:6]});
            bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            bytes.push_back({4'b1110, cp[15:12]});
            bytes.push_back({2'b10, cp[11:6]});
            bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            bytes.push_back({5'b11110, cp[20:18]});
            bytes.push_back({2'b10, cp[17:12]});
            bytes.push_back({2'b10, cp[11:6]});
            bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   function automatic void random_char(ref logic [7:0] bytes[$], input int force_len);
      logic [20:0] cp;
      int          len;
      if (force_len == 0 && $urandom_range(0, 99) < 40) begin
         cp = 21'(cp_edges[$urandom_range(0, 43)] + $urandom_range(0, 2) - 1);
         len = natural_len(cp);
      end else begin
         len = (force_len != 0) ? force_len : $urandom_range(1, 4);
         case (len)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range(0, 'h7FF));
            3: cp = 21'($urandom_range(0, 'hFFFF));
            default: cp = 21'($urandom_range(0, 'h1FFFFF));
         endcase
      end
      push_char(bytes, cp, len);
   endfunction

   function automatic void add_text(ref ucc_item_type text[$], input logic [7:0] bytes[$],
                                    input logic [31:0] caret_mask);
      ucc_item_type it;
      for (int i = 0; i < bytes.size(); i++) begin
         it.data_byte = bytes[i];
         it.before_caret = caret_mask[i];
         it.last_byte = (i == bytes.size() - 1);
         text.push_back(it);
      end
   endfunction

   task automatic build_random_text(ref ucc_item_type text[$]);
      logic [7:0]   bytes[$];
      logic [7:0]   tmp[$];
      ucc_item_type it;
      int           n_units;
      int           kind;
      int           keep;
      int           caret_at;
      bit           prefix_caret;
      n_units = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
      for (int u = 0; u < n_units; u++) begin
         kind = $urandom_range(0, 99);
         if (kind < 72) begin
            random_char(bytes, 0);
         end else if (kind < 82) begin
            bytes.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 92) begin
            tmp.delete();
            random_char(tmp, $urandom_range(2, 4));
            keep = $urandom_range(1, tmp.size() - 1);
            for (int k = 0; k < keep; k++) bytes.push_back(tmp[k]);
         end else begin
            keep = $urandom_range(1, 3);
            for (int k = 0; k < keep; k++) bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
         end
      end
      prefix_caret = $urandom_range(0, 99) < 75;
      caret_at = $urandom_range(0, bytes.size());
      for (int i = 0; i < bytes.size(); i++) begin
         it.data_byte = bytes[i];
         it.before_caret = prefix_caret ? (i < caret_at) : 1'($urandom_range(0, 1));
         it.last_byte = (i == bytes.size() - 1);
         text.push_back(it);
      end
   endtask

   task automatic send_byte(input ucc_item_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= it.data_byte;
      req_ch.before_caret <= it.before_caret;
      req_ch.last_byte <= it.last_byte;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_byte(it);
      bytes_sent++;
   endtask

   task automatic send_text(ref ucc_item_type text[$]);
      foreach (text[i]) send_byte(text[i]);
      text.delete();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.before_caret = 1'b0;
      req_ch.last_byte = 1'b0;
   end

   initial begin
      ucc_result_type got;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.code_point = rsp_ch.code_point;
            got.char_width = rsp_ch.char_width;
            got.char_done = rsp_ch.char_done;
            got.column_total = rsp_ch.column_total;
            got.char_total = rsp_ch.char_total;
            got.text_done = rsp_ch.text_done;
            sb.check_result(got);
         end
         rsp_ch.ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      ucc_item_type text[$];
      int           phase_start;
      int           waited;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed texts: field extremes, every sequence length, absorbed and stray
      // continuations, malformed and cut-short sequences, and a caret that is not a prefix.
      add_text(text, '{8'h00, 8'h7F}, '1);
      add_text(text, '{8'hC3, 8'hA9, 8'hCC, 8'h80, 8'hE4, 8'hB8, 8'h80,
                       8'hF0, 8'h9F, 8'h98, 8'h80, 8'hBF}, '1);
      add_text(text, '{8'h80, 8'hBF, 8'h41}, '1);
      add_text(text, '{8'hC3, 8'h41, 8'hFF, 8'hF8, 8'hE4, 8'hB8}, '1);
      add_text(text, '{8'hF0}, '1);
      add_text(text, '{8'h41, 8'h42, 8'hE4, 8'hB8, 8'h80}, 32'b11010);
      send_text(text);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         if (phase == 0) begin
            fork
               begin
                  rsp_hold <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
            join_none
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_random_text(text);
            send_text(text);
         end
      end
      req_ch.valid <= 1'b0;

      waited = 0;
      while (sb.pending_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (sb.pending_results.size() != 0) begin
         $error("%0d expected result items never arrived", sb.pending_results.size());
         sb.fail_count++;
      end

      $display("Run covered %0d bytes in %0d texts, settling %0d characters.",
               bytes_sent, sb.texts_seen, sb.chars_settled);
      $display("Idle patterns: none, sender gaps, receiver stalls, both, plus one long hold.");
      if (sb.fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
